/* hdl/point_distance_shaker_sort_macros.svh */
// Assertion macros used by the point distance sorter top level.
`ifndef POINT_DISTANCE_SHAKER_SORT_MACROS_SVH
`define POINT_DISTANCE_SHAKER_SORT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PDSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdss: check failed");

// Next-cycle implication, checked out of reset.
`define PDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdss: check failed");

`endif

/* hdl/pdss_pkg.sv */
// Package with the widths, types and command structs of the point distance sorter.
`timescale 1ns / 1ps

package pdss_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned DSQ_W      = 32;
  localparam int unsigned ROOT_W     = 24;
  localparam int unsigned RAD_W      = 2 * ROOT_W;
  localparam int unsigned FRAC_W     = RAD_W - DSQ_W;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned ITER_W     = $clog2(ROOT_W);

  // One stored point with its sort key
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DSQ_W-1:0]          dsq;
  } point_t;

  // Source of the word written into the point store
  typedef enum logic [1:0] {
    WR_STAGE,
    WR_CARRY,
    WR_STEP
  } wr_src_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             capture;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    wr_src_e          wr_src;
    logic             load_carry;
    logic             dir_fwd;
    logic             sqrt_start;
    logic             sqrt_step;
    logic             push;
    logic             push_last;
    logic             push_drop;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic greater;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/point_distance_shaker_sort.sv */
// Point distance sorter: loads up to 64 signed points per set, then emits them nearest first.
// Points enter one beat per cycle; the beat flagged last closes the set. The set is then put
// in stable ascending order of x*x + y*y by shaker passes over a point store with one read and
// one write port: each pass moves one compare-exchange per cycle, and passes stop early once
// one makes no swap. Each result is then read from the store, goes through 24 steps of the
// bit-serial root and is handed over once the output register is free. Inputs are refused
// from the closing beat until the farthest point, marked end_of_list, has been handed to the
// output register; points_dropped on that beat tells that points arrived while the store was
// full. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "point_distance_shaker_sort_macros.svh"

module point_distance_shaker_sort (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pdss_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pdss_pkg::COORD_W-1:0] point_y_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pdss_pkg::COORD_W-1:0] sorted_x_o,
  output logic signed [pdss_pkg::COORD_W-1:0] sorted_y_o,
  output logic [pdss_pkg::DSQ_W-1:0]          distance_squared_o,
  output logic [pdss_pkg::ROOT_W-1:0]         distance_fixed_o,
  output logic                                end_of_list_o,
  output logic                                points_dropped_o
);

  pdss_pkg::dp_cmd_t cmd;
  pdss_pkg::dp_sts_t sts;

  pdss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  pdss_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .point_x_i          (point_x_i),
    .point_y_i          (point_y_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sorted_x_o         (sorted_x_o),
    .sorted_y_o         (sorted_y_o),
    .distance_squared_o (distance_squared_o),
    .distance_fixed_o   (distance_fixed_o),
    .end_of_list_o      (end_of_list_o),
    .points_dropped_o   (points_dropped_o)
  );

  // While loading, only fresh points are written to the store
  `PDSS_ASSERT_NOW(a_load_writes, clk_i, rst_ni, in_ready_o && cmd.wr_en, cmd.wr_src == pdss_pkg::WR_STAGE)
  // A result is handed over only into a free output register
  `PDSS_ASSERT_NOW(a_push_free, clk_i, rst_ni, cmd.push, sts.out_free)
  // The drop flag rides only on the final result
  `PDSS_ASSERT_NOW(a_drop_last, clk_i, rst_ni, cmd.push_drop, cmd.push && cmd.push_last)
  // After the final result the block takes points again
  `PDSS_ASSERT_NEXT(a_reload, clk_i, rst_ni, cmd.push && cmd.push_last, in_ready_o)

endmodule

/* hdl/pdss_datapath.sv */
// Datapath: point store, squaring stage, compare-exchange carry, bit-serial root, output beat.
`timescale 1ns / 1ps

module pdss_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [pdss_pkg::COORD_W-1:0]   point_x_i,
  input  logic signed [pdss_pkg::COORD_W-1:0]   point_y_i,
  input  pdss_pkg::dp_cmd_t                     cmd_i,
  output pdss_pkg::dp_sts_t                     sts_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pdss_pkg::COORD_W-1:0]   sorted_x_o,
  output logic signed [pdss_pkg::COORD_W-1:0]   sorted_y_o,
  output logic [pdss_pkg::DSQ_W-1:0]            distance_squared_o,
  output logic [pdss_pkg::ROOT_W-1:0]           distance_fixed_o,
  output logic                                  end_of_list_o,
  output logic                                  points_dropped_o
);

  logic signed [pdss_pkg::COORD_W-1:0]   stage_x_q, stage_y_q;
  logic signed [2*pdss_pkg::COORD_W-1:0] sq_x_q, sq_y_q;
  logic [pdss_pkg::DSQ_W-1:0]            stage_dsq;
  pdss_pkg::point_t                      stage_pt;
  pdss_pkg::point_t                      point_store_q [pdss_pkg::MAX_POINTS];
  pdss_pkg::point_t                      rdata_q;
  pdss_pkg::point_t                      carry_q;
  pdss_pkg::point_t                      wdata;
  logic                                  greater;
  logic                                  keep_carry;

  logic [pdss_pkg::RAD_W-1:0]            rad_q;
  logic [pdss_pkg::REM_W-1:0]            rem_q;
  logic [pdss_pkg::ROOT_W-1:0]           root_q;
  logic [pdss_pkg::REM_W+1:0]            trial;
  logic [pdss_pkg::REM_W+1:0]            test;
  logic [pdss_pkg::REM_W+1:0]            diff;

  logic                                  out_valid_q;
  logic signed [pdss_pkg::COORD_W-1:0]   out_x_q, out_y_q;
  logic [pdss_pkg::DSQ_W-1:0]            out_dsq_q;
  logic [pdss_pkg::ROOT_W-1:0]           out_root_q;
  logic                                  out_last_q;
  logic                                  out_drop_q;

  // Square the coordinates of an incoming beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      stage_x_q <= point_x_i;
      stage_y_q <= point_y_i;
      sq_x_q    <= (2*pdss_pkg::COORD_W)'(point_x_i) * (2*pdss_pkg::COORD_W)'(point_x_i);
      sq_y_q    <= (2*pdss_pkg::COORD_W)'(point_y_i) * (2*pdss_pkg::COORD_W)'(point_y_i);
    end
  end

  // Sum the squares; each is at most 2^30
  assign stage_dsq = {1'b0, sq_x_q[2*pdss_pkg::COORD_W-2:0]}
                   + {1'b0, sq_y_q[2*pdss_pkg::COORD_W-2:0]};
  assign stage_pt  = '{x: stage_x_q, y: stage_y_q, dsq: stage_dsq};

  // Strict compare keeps equal keys in load order
  assign greater    = cmd_i.dir_fwd ? (carry_q.dsq > rdata_q.dsq)
                                    : (rdata_q.dsq > carry_q.dsq);
  assign keep_carry = greater;

  // Select the store write word
  always_comb begin
    unique case (cmd_i.wr_src)
      pdss_pkg::WR_STAGE: wdata = stage_pt;
      pdss_pkg::WR_CARRY: wdata = carry_q;
      pdss_pkg::WR_STEP:  wdata = keep_carry ? rdata_q : carry_q;
      default:            wdata = carry_q;
    endcase
  end

  // Point store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      point_store_q[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= point_store_q[cmd_i.rd_addr];
    end
  end

  // Carry the running extreme through a pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_carry) begin
      carry_q <= rdata_q;
    end else if (cmd_i.wr_en && (cmd_i.wr_src == pdss_pkg::WR_STEP) && !keep_carry) begin
      carry_q <= rdata_q;
    end
  end

  // Restoring square root, one result bit per step
  assign trial = {rem_q, rad_q[pdss_pkg::RAD_W-1 -: 2]};
  assign test  = {2'b00, root_q, 2'b01};
  assign diff  = trial - test;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= {rdata_q.dsq, {pdss_pkg::FRAC_W{1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[pdss_pkg::RAD_W-3:0], 2'b00};
      if (trial >= test) begin
        rem_q  <= diff[pdss_pkg::REM_W-1:0];
        root_q <= {root_q[pdss_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= trial[pdss_pkg::REM_W-1:0];
        root_q <= {root_q[pdss_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_x_q    <= rdata_q.x;
      out_y_q    <= rdata_q.y;
      out_dsq_q  <= rdata_q.dsq;
      out_root_q <= root_q;
      out_last_q <= cmd_i.push_last;
      out_drop_q <= cmd_i.push_drop;
    end
  end

  assign sts_o.greater  = greater;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign sorted_x_o         = out_x_q;
  assign sorted_y_o         = out_y_q;
  assign distance_squared_o = out_dsq_q;
  assign distance_fixed_o   = out_root_q;
  assign end_of_list_o      = out_last_q;
  assign points_dropped_o   = out_drop_q;

endmodule

/* hdl/pdss_ctrl.sv */
// Controller: load counting, shaker pass sequencing and readout sequencing.
`timescale 1ns / 1ps

module pdss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_point_i,
  output logic                in_ready_o,
  input  pdss_pkg::dp_sts_t   sts_i,
  output pdss_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [13:0] {
    S_LOAD   = 14'h0001,
    S_CLOSE  = 14'h0002,
    S_F_RD   = 14'h0004,
    S_F_LD   = 14'h0008,
    S_F_CMP  = 14'h0010,
    S_F_END  = 14'h0020,
    S_B_RD   = 14'h0040,
    S_B_LD   = 14'h0080,
    S_B_CMP  = 14'h0100,
    S_B_END  = 14'h0200,
    S_R_RD   = 14'h0400,
    S_R_LD   = 14'h0800,
    S_R_SQRT = 14'h1000,
    S_R_PUSH = 14'h2000
  } state_e;

  state_e                       state_q, state_d;
  logic [pdss_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         ovf_q, ovf_d;
  logic                         stage_q, stage_d;
  logic [pdss_pkg::IDX_W-1:0]   lo_q, lo_d;
  logic [pdss_pkg::IDX_W-1:0]   hi_q, hi_d;
  logic [pdss_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [pdss_pkg::IDX_W-1:0]   k_q, k_d;
  logic                         swapped_q, swapped_d;
  logic [pdss_pkg::ITER_W-1:0]  iter_q, iter_d;
  logic                         accept;
  logic                         is_last;
  logic [pdss_pkg::IDX_W-1:0]   hi_dec;
  logic [pdss_pkg::IDX_W-1:0]   lo_inc;

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign is_last    = ((pdss_pkg::CNT_W'(k_q) + pdss_pkg::CNT_W'(1)) == count_q);
  assign hi_dec     = hi_q - pdss_pkg::IDX_W'(1);
  assign lo_inc     = lo_q + pdss_pkg::IDX_W'(1);

  // Sequence load, sort passes and readout
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    stage_d   = 1'b0;
    lo_d      = lo_q;
    hi_d      = hi_q;
    idx_d     = idx_q;
    k_d       = k_q;
    swapped_d = swapped_q;
    iter_d    = iter_q;
    cmd_o        = '0;
    cmd_o.wr_src = pdss_pkg::WR_STAGE;

    // Store the squared point in the cycle after its beat, or drop it when full
    if (stage_q) begin
      if (count_q < pdss_pkg::CNT_W'(pdss_pkg::MAX_POINTS)) begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = count_q[pdss_pkg::IDX_W-1:0];
        count_d       = count_q + pdss_pkg::CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          stage_d       = 1'b1;
          if (last_point_i) begin
            state_d = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        lo_d = '0;
        k_d  = '0;
        hi_d = pdss_pkg::IDX_W'(count_d - pdss_pkg::CNT_W'(1));
        if (count_d == pdss_pkg::CNT_W'(1)) begin
          state_d = S_R_RD;
        end else begin
          state_d = S_F_RD;
        end
      end
      // Forward pass: carry the largest key up to hi
      S_F_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = lo_q;
        idx_d         = lo_inc;
        swapped_d     = 1'b0;
        state_d       = S_F_LD;
      end
      S_F_LD: begin
        cmd_o.load_carry = 1'b1;
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_addr    = idx_q;
        state_d          = S_F_CMP;
      end
      S_F_CMP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = idx_q - pdss_pkg::IDX_W'(1);
        cmd_o.wr_src  = pdss_pkg::WR_STEP;
        cmd_o.dir_fwd = 1'b1;
        swapped_d     = swapped_q || sts_i.greater;
        if (idx_q == hi_q) begin
          state_d = S_F_END;
        end else begin
          idx_d         = idx_q + pdss_pkg::IDX_W'(1);
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_q + pdss_pkg::IDX_W'(1);
        end
      end
      S_F_END: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = hi_q;
        cmd_o.wr_src  = pdss_pkg::WR_CARRY;
        hi_d          = hi_dec;
        if (!swapped_q || (lo_q >= hi_dec)) begin
          state_d = S_R_RD;
        end else begin
          state_d = S_B_RD;
        end
      end
      // Backward pass: carry the smallest key down to lo
      S_B_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = hi_q;
        idx_d         = hi_dec;
        swapped_d     = 1'b0;
        state_d       = S_B_LD;
      end
      S_B_LD: begin
        cmd_o.load_carry = 1'b1;
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_addr    = idx_q;
        state_d          = S_B_CMP;
      end
      S_B_CMP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = idx_q + pdss_pkg::IDX_W'(1);
        cmd_o.wr_src  = pdss_pkg::WR_STEP;
        swapped_d     = swapped_q || sts_i.greater;
        if (idx_q == lo_q) begin
          state_d = S_B_END;
        end else begin
          idx_d         = idx_q - pdss_pkg::IDX_W'(1);
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_q - pdss_pkg::IDX_W'(1);
        end
      end
      S_B_END: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = lo_q;
        cmd_o.wr_src  = pdss_pkg::WR_CARRY;
        lo_d          = lo_inc;
        if (!swapped_q || (lo_inc >= hi_q)) begin
          state_d = S_R_RD;
        end else begin
          state_d = S_F_RD;
        end
      end
      // Readout: fetch, take the root, hand over the beat
      S_R_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = k_q;
        state_d       = S_R_LD;
      end
      S_R_LD: begin
        cmd_o.sqrt_start = 1'b1;
        iter_d           = '0;
        state_d          = S_R_SQRT;
      end
      S_R_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        iter_d          = iter_q + pdss_pkg::ITER_W'(1);
        if (iter_q == pdss_pkg::ITER_W'(pdss_pkg::ROOT_W - 1)) begin
          state_d = S_R_PUSH;
        end
      end
      S_R_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = is_last;
          cmd_o.push_drop = is_last && ovf_q;
          if (is_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + pdss_pkg::IDX_W'(1);
            state_d = S_R_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      stage_q   <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      idx_q     <= '0;
      k_q       <= '0;
      swapped_q <= 1'b0;
      iter_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      stage_q   <= stage_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      swapped_q <= swapped_d;
      iter_q    <= iter_d;
    end
  end

endmodule
